>>> hdl/ipv4_dap_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4_dap_pkg
// shared types and constants of the dotted-address parser
// ----------------------------------------------------------------------------
package ipv4_dap_pkg;

    // request kinds on the input channel
    localparam logic OP_CHAR = 1'b0;
    localparam logic OP_END  = 1'b1;

    // character codes
    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_SEVEN = 8'h37;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    // saturation value of a part (2^32)
    localparam logic [32:0] VALUE_CAP = 33'h1_0000_0000;
    // largest index of a part
    localparam logic [2:0] LAST_PART = 3'd3;

    typedef enum logic [1:0] {
        MODE_EMPTY = 2'd0,
        MODE_DEC   = 2'd1,
        MODE_OCT   = 2'd2
    } part_mode_t;

    typedef struct packed {
        logic       operation;
        logic [7:0] char_code;
    } item_t;

    typedef struct packed {
        logic        ok;
        logic [31:0] address;
    } result_t;

endpackage

>>> hdl/ipv4_dap_in_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4_dap_in_reg
// input register stage, takes a request every cycle when the parser moves
// ----------------------------------------------------------------------------
module ipv4_dap_in_reg (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_operation,
    input  logic [7:0]           s_char_code,
    output logic                 item_valid,
    output ipv4_dap_pkg::item_t  item,
    input  logic                 item_ready
);
    import ipv4_dap_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    assign s_ready    = !valid_reg || item_ready;
    assign valid_next = s_ready ? s_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        if (s_ready && s_valid) begin
            item_reg.operation <= s_operation;
            item_reg.char_code <= s_char_code;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

>>> hdl/ipv4_dap_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4_dap_core
// parse state and per-character update, builds the result on end requests
// ----------------------------------------------------------------------------
module ipv4_dap_core (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    item_valid,
    input  ipv4_dap_pkg::item_t     item,
    output logic                    item_ready,
    output logic                    res_valid,
    output ipv4_dap_pkg::result_t   res,
    input  logic                    res_ready
);
    import ipv4_dap_pkg::*;

    logic [2:0]  part_index_reg, part_index_next;
    logic [32:0] part_value_reg, part_value_next;
    logic        overflow_reg, overflow_next;
    part_mode_t  part_mode_reg, part_mode_next;
    logic [31:0] assembled_reg, assembled_next;
    logic        error_reg, error_next;

    logic        take;
    logic        is_end;
    logic [7:0]  code;
    logic [7:0]  code_off;
    logic [3:0]  digit;
    logic        is_digit;
    logic        is_octal_digit;
    logic [36:0] wide_value;
    logic [36:0] acc_dec;
    logic [36:0] acc_oct;
    logic [36:0] acc_sel;
    logic        fits;
    logic [31:0] end_address;

    assign is_end     = (item.operation == OP_END);
    assign item_ready = !is_end || res_ready;
    assign take       = item_valid && item_ready;
    assign res_valid  = take && is_end;

    assign code           = item.char_code;
    assign code_off       = code - CHAR_ZERO;
    assign digit          = code_off[3:0];
    assign is_digit       = (code >= CHAR_ZERO) && (code <= CHAR_NINE);
    assign is_octal_digit = (code <= CHAR_SEVEN);

    // value * 10 + d and value * 8 + d, never past 2^36
    assign wide_value = {4'b0, part_value_reg};
    assign acc_dec    = (wide_value << 3) + (wide_value << 1) + {33'b0, digit};
    assign acc_oct    = (wide_value << 3) + {33'b0, digit};
    assign acc_sel    = (part_mode_reg == MODE_OCT) ? acc_oct : acc_dec;

    // last part must fit the bytes left over
    always_comb begin
        case (part_index_reg)
            3'd0:    fits = !part_value_reg[32];
            3'd1:    fits = (part_value_reg[32:24] == 9'd0);
            3'd2:    fits = (part_value_reg[32:16] == 17'd0);
            3'd3:    fits = (part_value_reg[32:8] == 25'd0);
            default: fits = 1'b0;
        endcase
    end

    // last part fills the top bytes, its low byte in the top byte
    always_comb begin
        end_address = assembled_reg;
        for (int k = 0; k < 4; k++) begin
            if (k + int'(part_index_reg) <= 3) begin
                end_address[8*(3-k) +: 8] = end_address[8*(3-k) +: 8]
                                          | part_value_reg[8*k +: 8];
            end
        end
    end

    always_comb begin
        res.ok      = !error_reg && (part_mode_reg != MODE_EMPTY) && !overflow_reg
                   && (part_index_reg <= LAST_PART) && fits;
        res.address = res.ok ? end_address : 32'd0;
    end

    always_comb begin
        part_index_next = part_index_reg;
        part_value_next = part_value_reg;
        overflow_next   = overflow_reg;
        part_mode_next  = part_mode_reg;
        assembled_next  = assembled_reg;
        error_next      = error_reg;
        if (take) begin
            if (is_end) begin
                part_index_next = 3'd0;
                part_value_next = 33'd0;
                overflow_next   = 1'b0;
                part_mode_next  = MODE_EMPTY;
                assembled_next  = 32'd0;
                error_next      = 1'b0;
            end else if (!error_reg) begin
                if (code == CHAR_DOT) begin
                    if (part_mode_reg == MODE_EMPTY || overflow_reg
                        || part_value_reg[32:8] != 25'd0
                        || part_index_reg >= LAST_PART) begin
                        error_next = 1'b1;
                    end else begin
                        for (int b = 0; b < 3; b++) begin
                            if (part_index_reg[1:0] == 2'(b)) begin
                                assembled_next[8*b +: 8] = assembled_reg[8*b +: 8]
                                                         | part_value_reg[7:0];
                            end
                        end
                        part_index_next = part_index_reg + 3'd1;
                        part_value_next = 33'd0;
                        overflow_next   = 1'b0;
                        part_mode_next  = MODE_EMPTY;
                    end
                end else if (!is_digit) begin
                    error_next = 1'b1;
                end else if (part_mode_reg == MODE_EMPTY) begin
                    part_mode_next  = (code == CHAR_ZERO) ? MODE_OCT : MODE_DEC;
                    part_value_next = {29'd0, digit};
                end else if (part_mode_reg == MODE_OCT && !is_octal_digit) begin
                    error_next = 1'b1;
                end else if (acc_sel[36:32] != 5'd0) begin
                    overflow_next   = 1'b1;
                    part_value_next = VALUE_CAP;
                end else begin
                    part_value_next = acc_sel[32:0];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            part_index_reg <= 3'd0;
            part_value_reg <= 33'd0;
            overflow_reg   <= 1'b0;
            part_mode_reg  <= MODE_EMPTY;
            assembled_reg  <= 32'd0;
            error_reg      <= 1'b0;
        end else begin
            part_index_reg <= part_index_next;
            part_value_reg <= part_value_next;
            overflow_reg   <= overflow_next;
            part_mode_reg  <= part_mode_next;
            assembled_reg  <= assembled_next;
            error_reg      <= error_next;
        end
    end

    a_index_range: assert property (@(posedge aclk) disable iff (!aresetn)
        part_index_reg <= LAST_PART)
        else $error("part index past last part");

    a_overflow_saturates: assert property (@(posedge aclk) disable iff (!aresetn)
        overflow_reg |-> (part_value_reg == VALUE_CAP))
        else $error("overflowed part not saturated");

    a_end_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (take && is_end) |=> (part_index_reg == 3'd0 && part_mode_reg == MODE_EMPTY
                              && !error_reg && assembled_reg == 32'd0))
        else $error("state not cleared after end request");

    a_reject_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && !res.ok) |-> (res.address == 32'd0))
        else $error("rejected result carries an address");

endmodule

>>> hdl/ipv4_dap_out_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4_dap_out_reg
// result register, loads a new result while the old one is being taken
// ----------------------------------------------------------------------------
module ipv4_dap_out_reg (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   res_valid,
    input  ipv4_dap_pkg::result_t  res,
    output logic                   res_ready,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic                   m_ok,
    output logic [31:0]            m_address
);
    import ipv4_dap_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign res_ready  = !valid_reg || m_ready;
    assign valid_next = res_ready ? res_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        if (res_ready && res_valid) begin
            res_reg <= res;
        end
    end

    assign m_valid   = valid_reg;
    assign m_ok      = res_reg.ok;
    assign m_address = res_reg.address;

endmodule

>>> hdl/ipv4_dotted_address_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4_dotted_address_parser
// streaming inet_aton-style ipv4 text parser
// ----------------------------------------------------------------------------
// A string comes in as one character request per cycle (s_operation low)
// followed by one end request (s_operation high, s_char_code ignored). The
// text holds one to four dot-separated parts, decimal, or octal when a part
// starts with '0'; every part but the last must be below 256 and lands in
// byte number part_index of the address (first octet in the low byte), the
// last part fills the remaining bytes from the top down. Each end request
// gives exactly one result: m_ok, and m_address (zero when not ok); character
// requests give none. The block takes one request every cycle unless an end
// request is held back: a request sits in an input register, the parse state
// advances by one character through a single multiply-by-ten-or-eight add per
// cycle, and the result is held in an output register so new characters keep
// flowing while a result waits. m_valid rises when an end request, past the
// input register, loads the free result register; an end request waits in the
// input register while an earlier result is still held. Rejected strings:
// empty string or part, trailing dot, five or more parts, stray characters
// (including a hex prefix), 8 or 9 in an octal part, oversized parts.
// ----------------------------------------------------------------------------
module ipv4_dotted_address_parser (
    input  logic        aclk,
    input  logic        aresetn,
    // request channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_operation,
    input  logic [7:0]  s_char_code,
    // result channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_ok,
    output logic [31:0] m_address
);
    import ipv4_dap_pkg::*;

    // registered request toward the parser
    logic    item_valid;
    logic    item_ready;
    item_t   item;

    // finished result toward the output register
    logic    res_valid;
    logic    res_ready;
    result_t res;

    // input register stage
    ipv4_dap_in_reg u_in_reg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_operation (s_operation),
        .s_char_code (s_char_code),
        .item_valid  (item_valid),
        .item        (item),
        .item_ready  (item_ready)
    );

    // parse state, consumes characters freely, end requests need a free slot
    ipv4_dap_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (item_valid),
        .item       (item),
        .item_ready (item_ready),
        .res_valid  (res_valid),
        .res        (res),
        .res_ready  (res_ready)
    );

    // result register
    ipv4_dap_out_reg u_out_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (res_valid),
        .res       (res),
        .res_ready (res_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_ok      (m_ok),
        .m_address (m_address)
    );

endmodule
